@@ src/vcsg_pkg.sv @@
// Shared definitions for the velocity command safety gate.
// Event codes, gate reason codes, field widths and register reset values.
// No dependencies.
package vcsg_pkg;

  // Field widths
  localparam int OP_W     = 3;
  localparam int SPEED_W  = 16;
  localparam int LIMIT_W  = 15;
  localparam int TICKS_W  = 16;
  localparam int WINDOW_W = TICKS_W + 1;
  localparam int AGE_W    = 18;
  localparam int REASON_W = 3;
  localparam int PRIOR_W  = 4;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 56;

  // APB port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Event codes carried in s_tuser
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_COMMAND = 3'd1;
  localparam logic [OP_W-1:0] OP_ODOM    = 3'd2;
  localparam logic [OP_W-1:0] OP_TRAJ    = 3'd3;
  localparam logic [OP_W-1:0] OP_BEAT    = 3'd4;
  localparam logic [OP_W-1:0] OP_ESTOP   = 3'd5;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED  = 3'd7;

  // Gate reasons, in priority order after active
  localparam logic [REASON_W-1:0] REASON_ACTIVE   = 3'd0;
  localparam logic [REASON_W-1:0] REASON_DISABLED = 3'd1;
  localparam logic [REASON_W-1:0] REASON_ESTOP    = 3'd2;
  localparam logic [REASON_W-1:0] REASON_ODOM     = 3'd3;
  localparam logic [REASON_W-1:0] REASON_BEAT     = 3'd4;
  localparam logic [REASON_W-1:0] REASON_TRAJ     = 3'd5;
  localparam logic [REASON_W-1:0] REASON_CMD      = 3'd6;
  localparam logic [REASON_W-1:0] REASON_INVALID  = 3'd7;
  localparam logic [PRIOR_W-1:0]  PRIOR_NONE      = 4'd15;

  // Register indexes
  localparam logic [2:0] REG_LIMIT_VX   = 3'd0;
  localparam logic [2:0] REG_LIMIT_VY   = 3'd1;
  localparam logic [2:0] REG_LIMIT_VYAW = 3'd2;
  localparam logic [2:0] REG_ODOM_LIM   = 3'd3;
  localparam logic [2:0] REG_TRAJ_BASE  = 3'd4;
  localparam logic [2:0] REG_BEAT_LIM   = 3'd5;
  localparam logic [2:0] REG_CMD_LIM    = 3'd6;

  // Register reset values
  localparam logic [LIMIT_W-1:0] RST_LIMIT_VX   = 15'd307;
  localparam logic [LIMIT_W-1:0] RST_LIMIT_VY   = 15'd205;
  localparam logic [LIMIT_W-1:0] RST_LIMIT_VYAW = 15'd512;
  localparam logic [TICKS_W-1:0] RST_ODOM_LIM   = 16'd15;
  localparam logic [TICKS_W-1:0] RST_TRAJ_BASE  = 16'd50;
  localparam logic [TICKS_W-1:0] RST_BEAT_LIM   = 16'd20;
  localparam logic [TICKS_W-1:0] RST_CMD_LIM    = 16'd15;

  // Source index into seen flags and ages
  localparam int SRC_ODOM = 0;
  localparam int SRC_BEAT = 1;
  localparam int SRC_TRAJ = 2;
  localparam int SRC_CMD  = 3;
  localparam int NUM_SRC  = 4;

  // One input item
  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [SPEED_W-1:0] cmd_vx;
    logic signed [SPEED_W-1:0] cmd_vy;
    logic signed [SPEED_W-1:0] cmd_vyaw;
    logic                      cmd_is_finite;
    logic [TICKS_W-1:0]        span_ticks;
    logic                      level;
  } item_t;

  // Symmetric clamp of a signed speed to +/- lim
  function automatic logic signed [SPEED_W-1:0] clamp_speed(
    input logic signed [SPEED_W-1:0] v,
    input logic [LIMIT_W-1:0]        lim
  );
    logic signed [SPEED_W:0] vx;
    logic signed [SPEED_W:0] hi;
    logic signed [SPEED_W:0] lo;
    logic signed [SPEED_W:0] r;
    vx = {v[SPEED_W-1], v};
    hi = $signed({{(SPEED_W+1-LIMIT_W){1'b0}}, lim});
    lo = -hi;
    r  = vx;
    if (vx > hi) r = hi;
    if (vx < lo) r = lo;
    return r[SPEED_W-1:0];
  endfunction

endpackage

@@ src/velocity_command_safety_gate.sv @@
// Velocity command safety gate: motion interlock with clamped command output.
// Uses vcsg_pkg for codes, widths, reset values and the clamp function.
//
// Usage:
//  Input stream (s_*): one event per transfer. s_tuser carries the event code
//  (tick, command, odometry, trajectory, heartbeat, emergency, enable); s_tdata
//  carries the command, finite flag, trajectory span and level.
//  Output stream (m_*): one transfer per tick event, with the clamped command or
//  zeros, the gate reason and a reason-changed flag. Other events give none.
//  Config (APB): seven registers at byte addresses 0..24, written by the user
//  only while idle; not enforced by the block. Reads return current values.
//  Flow: an accepted event is registered in the input register, then evaluated;
//  a tick's result enters the result register (m_tdata) once that slot is free.
//  Throughput: one event per cycle unless a tick waits on m_tready, set by the
//  single input register and the single result register.
//  Stall: while a result waits on m_tready, the input register still takes one
//  more event; non-tick events keep flowing, a second tick waits.
//  Reset (rst, synchronous): motion disabled, no source seen, ages and held
//  command zero, registers back to their defaults, both streams empty.
module velocity_command_safety_gate (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata, low bit up: cmd_vx[15:0], cmd_vy[15:0], cmd_vyaw[15:0],
  // cmd_is_finite, span_ticks[15:0], level, zero pad[5:0]
  input  logic [vcsg_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: op[2:0]
  input  logic [vcsg_pkg::OP_W-1:0]       s_tuser,
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata, low bit up: out_vx[15:0], out_vy[15:0], out_vyaw[15:0],
  // gate_reason[2:0], reason_changed, zero pad[3:0]
  output logic [vcsg_pkg::OUT_DATA_W-1:0] m_tdata,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vcsg_pkg::ADDR_W-1:0]     paddr,
  input  logic [vcsg_pkg::DATA_W-1:0]     pwdata,
  output logic [vcsg_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import vcsg_pkg::*;

  // Configuration registers
  logic [LIMIT_W-1:0] limit_vx;
  logic [LIMIT_W-1:0] limit_vy;
  logic [LIMIT_W-1:0] limit_vyaw;
  logic [TICKS_W-1:0] odom_limit_ticks;
  logic [TICKS_W-1:0] traj_base_ticks;
  logic [TICKS_W-1:0] beat_limit_ticks;
  logic [TICKS_W-1:0] cmd_limit_ticks;

  // Gate state
  logic                      motion_enabled;
  logic                      estop_active;
  logic [NUM_SRC-1:0]        seen_flags;
  logic [AGE_W-1:0]          source_ages [NUM_SRC];
  logic [WINDOW_W-1:0]       traj_window;
  logic signed [SPEED_W-1:0] held_vx;
  logic signed [SPEED_W-1:0] held_vy;
  logic signed [SPEED_W-1:0] held_vyaw;
  logic                      held_finite;
  logic [PRIOR_W-1:0]        prior_reason;

  // Input register
  logic  in_valid;
  item_t in_item;

  // Result register
  logic signed [SPEED_W-1:0] out_vx;
  logic signed [SPEED_W-1:0] out_vy;
  logic signed [SPEED_W-1:0] out_vyaw;
  logic [REASON_W-1:0]       gate_reason;
  logic                      reason_changed;

  logic cfg_write;
  logic is_tick;
  logic advance;
  logic s_xfer;

  logic [AGE_W-1:0]          ages_next [NUM_SRC];
  logic [REASON_W-1:0]       reason_next;
  logic signed [SPEED_W-1:0] vx_next;
  logic signed [SPEED_W-1:0] vy_next;
  logic signed [SPEED_W-1:0] vyaw_next;

  // APB: always ready, write on access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_vx         <= RST_LIMIT_VX;
      limit_vy         <= RST_LIMIT_VY;
      limit_vyaw       <= RST_LIMIT_VYAW;
      odom_limit_ticks <= RST_ODOM_LIM;
      traj_base_ticks  <= RST_TRAJ_BASE;
      beat_limit_ticks <= RST_BEAT_LIM;
      cmd_limit_ticks  <= RST_CMD_LIM;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_LIMIT_VX:   limit_vx         <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_VY:   limit_vy         <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_VYAW: limit_vyaw       <= pwdata[LIMIT_W-1:0];
        REG_ODOM_LIM:   odom_limit_ticks <= pwdata[TICKS_W-1:0];
        REG_TRAJ_BASE:  traj_base_ticks  <= pwdata[TICKS_W-1:0];
        REG_BEAT_LIM:   beat_limit_ticks <= pwdata[TICKS_W-1:0];
        REG_CMD_LIM:    cmd_limit_ticks  <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_LIMIT_VX:   prdata = {{(DATA_W-LIMIT_W){1'b0}}, limit_vx};
      REG_LIMIT_VY:   prdata = {{(DATA_W-LIMIT_W){1'b0}}, limit_vy};
      REG_LIMIT_VYAW: prdata = {{(DATA_W-LIMIT_W){1'b0}}, limit_vyaw};
      REG_ODOM_LIM:   prdata = {{(DATA_W-TICKS_W){1'b0}}, odom_limit_ticks};
      REG_TRAJ_BASE:  prdata = {{(DATA_W-TICKS_W){1'b0}}, traj_base_ticks};
      REG_BEAT_LIM:   prdata = {{(DATA_W-TICKS_W){1'b0}}, beat_limit_ticks};
      REG_CMD_LIM:    prdata = {{(DATA_W-TICKS_W){1'b0}}, cmd_limit_ticks};
      default:        prdata = '0;
    endcase
  end

  // Handshake: a tick needs a free result slot, other events always proceed
  assign is_tick  = (in_item.op == OP_TICK);
  assign advance  = in_valid && (!is_tick || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_xfer   = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_item.op            <= s_tuser;
      in_item.cmd_vx        <= s_tdata[15:0];
      in_item.cmd_vy        <= s_tdata[31:16];
      in_item.cmd_vyaw      <= s_tdata[47:32];
      in_item.cmd_is_finite <= s_tdata[48];
      in_item.span_ticks    <= s_tdata[64:49];
      in_item.level         <= s_tdata[65];
    end
  end

  // Saturating age increment for a tick
  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) begin
      ages_next[i] = (&source_ages[i]) ? source_ages[i] : source_ages[i] + 1'b1;
    end
  end

  // Reason priority on the aged values
  always_comb begin
    priority if (!motion_enabled)
      reason_next = REASON_DISABLED;
    else if (estop_active)
      reason_next = REASON_ESTOP;
    else if (!seen_flags[SRC_ODOM] ||
             ages_next[SRC_ODOM] > {{(AGE_W-TICKS_W){1'b0}}, odom_limit_ticks})
      reason_next = REASON_ODOM;
    else if (!seen_flags[SRC_BEAT] ||
             ages_next[SRC_BEAT] > {{(AGE_W-TICKS_W){1'b0}}, beat_limit_ticks})
      reason_next = REASON_BEAT;
    else if (!seen_flags[SRC_TRAJ] ||
             ages_next[SRC_TRAJ] > {{(AGE_W-WINDOW_W){1'b0}}, traj_window})
      reason_next = REASON_TRAJ;
    else if (!seen_flags[SRC_CMD] ||
             ages_next[SRC_CMD] > {{(AGE_W-TICKS_W){1'b0}}, cmd_limit_ticks})
      reason_next = REASON_CMD;
    else if (!held_finite)
      reason_next = REASON_INVALID;
    else
      reason_next = REASON_ACTIVE;
  end

  // Clamp and gate the held command
  always_comb begin
    if (reason_next == REASON_ACTIVE) begin
      vx_next   = clamp_speed(held_vx, limit_vx);
      vy_next   = clamp_speed(held_vy, limit_vy);
      vyaw_next = clamp_speed(held_vyaw, limit_vyaw);
    end else begin
      vx_next   = '0;
      vy_next   = '0;
      vyaw_next = '0;
    end
  end

  // State update, one event per cycle unless a tick waits on the result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_enabled <= 1'b0;
      estop_active   <= 1'b0;
      seen_flags     <= '0;
      for (int i = 0; i < NUM_SRC; i++) source_ages[i] <= '0;
      traj_window    <= '0;
      held_vx        <= '0;
      held_vy        <= '0;
      held_vyaw      <= '0;
      held_finite    <= 1'b1;
      prior_reason   <= PRIOR_NONE;
    end else if (advance) begin
      unique case (in_item.op)
        OP_TICK: begin
          for (int i = 0; i < NUM_SRC; i++) source_ages[i] <= ages_next[i];
          prior_reason <= {1'b0, reason_next};
        end
        OP_COMMAND: begin
          held_vx               <= in_item.cmd_vx;
          held_vy               <= in_item.cmd_vy;
          held_vyaw             <= in_item.cmd_vyaw;
          held_finite           <= in_item.cmd_is_finite;
          source_ages[SRC_CMD]  <= '0;
          seen_flags[SRC_CMD]   <= 1'b1;
        end
        OP_ODOM: begin
          source_ages[SRC_ODOM] <= '0;
          seen_flags[SRC_ODOM]  <= 1'b1;
        end
        OP_TRAJ: begin
          traj_window           <= {1'b0, traj_base_ticks} + {1'b0, in_item.span_ticks};
          source_ages[SRC_TRAJ] <= '0;
          seen_flags[SRC_TRAJ]  <= 1'b1;
        end
        OP_BEAT: begin
          source_ages[SRC_BEAT] <= '0;
          seen_flags[SRC_BEAT]  <= 1'b1;
        end
        OP_ESTOP: begin
          estop_active <= in_item.level;
        end
        OP_ENABLE: begin
          motion_enabled <= in_item.level;
          if (!in_item.level) begin
            held_vx     <= '0;
            held_vy     <= '0;
            held_vyaw   <= '0;
            held_finite <= 1'b1;
          end
        end
        OP_UNUSED: ;
        default: ;
      endcase
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && is_tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance && is_tick) begin
      out_vx         <= vx_next;
      out_vy         <= vy_next;
      out_vyaw       <= vyaw_next;
      gate_reason    <= reason_next;
      reason_changed <= ({1'b0, reason_next} != prior_reason);
    end
  end

  assign m_tdata = {4'b0, reason_changed, gate_reason, out_vyaw, out_vy, out_vx};

  // A blocked result must not be overwritten by a later tick
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(advance && is_tick))
    else $error("tick result overwrote a pending result");

  // A gated result carries zero motion
  a_gated_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && gate_reason != REASON_ACTIVE |->
      out_vx == '0 && out_vy == '0 && out_vyaw == '0)
    else $error("nonzero motion while gated");

  // The first tick after reset always flags a reason change
  a_first_change: assert property (@(posedge clk) disable iff (rst)
    advance && is_tick && prior_reason == PRIOR_NONE |=> reason_changed)
    else $error("first tick did not flag a reason change");

  // Disabling clears the held command
  a_disable_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_item.op == OP_ENABLE && !in_item.level |=>
      held_vx == '0 && held_vy == '0 && held_vyaw == '0 && held_finite)
    else $error("disable did not clear held command");

  // Input side only stalls while a tick waits on the result slot
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && is_tick && m_tvalid && !m_tready)
    else $error("input stalled without a blocked tick");

endmodule

@@ tb/gate_check_pkg.sv @@
`timescale 1ns / 1ps
// Prediction and checking for the velocity command safety gate testbench.
// Holds its own copy of the gate state and registers; depends on vcsg_pkg.
package gate_check_pkg;
  import vcsg_pkg::*;

  // One expected output transfer
  typedef struct {
    logic signed [SPEED_W-1:0] vx;
    logic signed [SPEED_W-1:0] vy;
    logic signed [SPEED_W-1:0] vyaw;
    logic [REASON_W-1:0]       reason;
    logic                      changed;
  } gate_out_t;

  class gate_output_checker;
    // Register copy
    logic [LIMIT_W-1:0] speed_lim [3];
    logic [TICKS_W-1:0] odom_lim;
    logic [TICKS_W-1:0] traj_base;
    logic [TICKS_W-1:0] beat_lim;
    logic [TICKS_W-1:0] cmd_lim;
    // Interlock state
    bit                        enabled;
    bit                        estop;
    bit [NUM_SRC-1:0]          seen;
    logic [AGE_W-1:0]          age [NUM_SRC];
    logic [WINDOW_W-1:0]       traj_window;
    logic signed [SPEED_W-1:0] held [3];
    bit                        held_finite;
    logic [PRIOR_W-1:0]        last_reason;
    gate_out_t                 expected_outputs [$];
    int                        errors;

    function new();
      speed_lim[0] = RST_LIMIT_VX;
      speed_lim[1] = RST_LIMIT_VY;
      speed_lim[2] = RST_LIMIT_VYAW;
      odom_lim     = RST_ODOM_LIM;
      traj_base    = RST_TRAJ_BASE;
      beat_lim     = RST_BEAT_LIM;
      cmd_lim      = RST_CMD_LIM;
      enabled      = 1'b0;
      estop        = 1'b0;
      seen         = '0;
      for (int i = 0; i < NUM_SRC; i++) age[i] = '0;
      traj_window  = '0;
      for (int i = 0; i < 3; i++) held[i] = '0;
      held_finite  = 1'b1;
      last_reason  = PRIOR_NONE;
      errors       = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_LIMIT_VX:   speed_lim[0] = value[LIMIT_W-1:0];
        REG_LIMIT_VY:   speed_lim[1] = value[LIMIT_W-1:0];
        REG_LIMIT_VYAW: speed_lim[2] = value[LIMIT_W-1:0];
        REG_ODOM_LIM:   odom_lim     = value[TICKS_W-1:0];
        REG_TRAJ_BASE:  traj_base    = value[TICKS_W-1:0];
        REG_BEAT_LIM:   beat_lim     = value[TICKS_W-1:0];
        REG_CMD_LIM:    cmd_lim      = value[TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // Symmetric clamp to +/- lim
    function logic signed [SPEED_W-1:0] limit_speed(logic signed [SPEED_W-1:0] v,
                                                    logic [LIMIT_W-1:0] lim);
      int s;
      int l;
      s = v;
      l = lim;
      if (s > l) s = l;
      if (s < -l) s = -l;
      return s[SPEED_W-1:0];
    endfunction

    function bit stale(int src, logic [WINDOW_W-1:0] lim);
      return !seen[src] || (age[src] > lim);
    endfunction

    function void arrive(int src);
      age[src]  = '0;
      seen[src] = 1'b1;
    endfunction

    // Update state for one accepted event; ticks queue an expected output
    function void note_event(item_t it);
      gate_out_t           res;
      logic [REASON_W-1:0] reason;
      case (it.op)
        OP_COMMAND: begin
          held[0]     = it.cmd_vx;
          held[1]     = it.cmd_vy;
          held[2]     = it.cmd_vyaw;
          held_finite = it.cmd_is_finite;
          arrive(SRC_CMD);
        end
        OP_ODOM: arrive(SRC_ODOM);
        OP_TRAJ: begin
          traj_window = {1'b0, traj_base} + {1'b0, it.span_ticks};
          arrive(SRC_TRAJ);
        end
        OP_BEAT:  arrive(SRC_BEAT);
        OP_ESTOP: estop = it.level;
        OP_ENABLE: begin
          enabled = it.level;
          if (!it.level) begin
            for (int i = 0; i < 3; i++) held[i] = '0;
            held_finite = 1'b1;
          end
        end
        OP_TICK: begin
          // ages first, saturating
          for (int i = 0; i < NUM_SRC; i++)
            if (age[i] != {AGE_W{1'b1}}) age[i] = age[i] + 1'b1;
          if (!enabled) reason = REASON_DISABLED;
          else if (estop) reason = REASON_ESTOP;
          else if (stale(SRC_ODOM, {1'b0, odom_lim})) reason = REASON_ODOM;
          else if (stale(SRC_BEAT, {1'b0, beat_lim})) reason = REASON_BEAT;
          else if (stale(SRC_TRAJ, traj_window)) reason = REASON_TRAJ;
          else if (stale(SRC_CMD, {1'b0, cmd_lim})) reason = REASON_CMD;
          else if (!held_finite) reason = REASON_INVALID;
          else reason = REASON_ACTIVE;
          if (reason == REASON_ACTIVE) begin
            res.vx   = limit_speed(held[0], speed_lim[0]);
            res.vy   = limit_speed(held[1], speed_lim[1]);
            res.vyaw = limit_speed(held[2], speed_lim[2]);
          end else begin
            res.vx   = '0;
            res.vy   = '0;
            res.vyaw = '0;
          end
          res.reason  = reason;
          res.changed = ({1'b0, reason} != last_reason);
          last_reason = {1'b0, reason};
          expected_outputs.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, longint got, longint want);
      if (got != want)
        report_mismatch($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    endtask

    // Check one output transfer against the oldest expectation
    task check_output(logic [OUT_DATA_W-1:0] data);
      gate_out_t want;
      if (expected_outputs.size() == 0) begin
        report_mismatch("output transfer with no tick outstanding");
      end else begin
        want = expected_outputs.pop_front();
        compare_field("out_vx", $signed(data[15:0]), want.vx);
        compare_field("out_vy", $signed(data[31:16]), want.vy);
        compare_field("out_vyaw", $signed(data[47:32]), want.vyaw);
        compare_field("gate_reason", data[50:48], want.reason);
        compare_field("reason_changed", data[51], want.changed);
      end
    endtask
  endclass

endpackage

@@ tb/tb_velocity_command_safety_gate.sv @@
`timescale 1ns / 1ps
// Top-level testbench for velocity_command_safety_gate: directed and random
// event streams with stream stalls and APB setup. Depends on vcsg_pkg, gate_check_pkg.
module tb_velocity_command_safety_gate;
  import vcsg_pkg::*;
  import gate_check_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int CHUNK_ITEMS = 150;
  localparam int NUM_CHUNKS  = 6;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  int     send_idle_pct = 35;
  int     recv_idle_pct = 50;
  longint cycle_count = 0;

  gate_output_checker gate_sb;

  velocity_command_safety_gate DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_velocity_command_safety_gate: errors");
      $finish;
    end
  end

  // Output side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst === 1'b0 && m_tvalid && m_tready) gate_sb.check_output(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one event and hold it until the transfer happens
  task automatic send_event(input item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {6'b0, it.level, it.span_ticks, it.cmd_is_finite,
                 it.cmd_vyaw, it.cmd_vy, it.cmd_vx};
    do @(posedge clk); while (!s_tready);
    gate_sb.note_event(it);
  endtask

  // Hold off input until all ticks are answered and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (gate_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    gate_sb.set_register(idx, value);
    @(posedge clk);
  endtask

  function automatic item_t make_event(logic [OP_W-1:0] op, logic [SPEED_W-1:0] vx,
                                       logic [SPEED_W-1:0] vy, logic [SPEED_W-1:0] vyaw,
                                       logic fin, logic [TICKS_W-1:0] span, logic level);
    item_t it;
    it.op            = op;
    it.cmd_vx        = vx;
    it.cmd_vy        = vy;
    it.cmd_vyaw      = vyaw;
    it.cmd_is_finite = fin;
    it.span_ticks    = span;
    it.level         = level;
    return it;
  endfunction

  // Speeds: full range, near typical limits, or corner values
  function automatic logic [SPEED_W-1:0] rand_speed();
    int r;
    logic [SPEED_W-1:0] mag;
    r = $urandom_range(9);
    mag = SPEED_W'($urandom_range(0, 1400));
    if (r < 3) return SPEED_W'($urandom_range(0, 65535));
    if (r < 8) return $urandom_range(1) ? -mag : mag;
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic item_t rand_event();
    item_t it;
    int r;
    int s;
    it.cmd_vx        = rand_speed();
    it.cmd_vy        = rand_speed();
    it.cmd_vyaw      = rand_speed();
    it.cmd_is_finite = ($urandom_range(9) != 0);
    it.level         = 1'($urandom_range(1));
    s = $urandom_range(9);
    if (s < 6) it.span_ticks = TICKS_W'($urandom_range(0, 40));
    else if (s < 9) it.span_ticks = TICKS_W'($urandom_range(0, 65535));
    else it.span_ticks = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    r = $urandom_range(99);
    if (r < 40) it.op = OP_TICK;
    else if (r < 55) it.op = OP_COMMAND;
    else if (r < 67) it.op = OP_ODOM;
    else if (r < 77) it.op = OP_BEAT;
    else if (r < 83) it.op = OP_TRAJ;
    else if (r < 88) begin
      it.op    = OP_ESTOP;
      it.level = ($urandom_range(9) < 3);
    end else if (r < 96) begin
      it.op    = OP_ENABLE;
      it.level = ($urandom_range(9) < 8);
    end else if (r < 98) it.op = OP_UNUSED;
    else it.op = OP_TICK;
    return it;
  endfunction

  // Register setting per chunk: both extremes first, then random ones
  task automatic apply_setting(input int k);
    logic [DATA_W-1:0] sp [3];
    logic [DATA_W-1:0] tk [4];
    for (int i = 0; i < 3; i++) begin
      case (k)
        0: sp[i] = 32767;
        1: sp[i] = 0;
        2: sp[i] = $urandom_range(0, 32767);
        default: sp[i] = $urandom_range(0, 1200);
      endcase
    end
    for (int i = 0; i < 4; i++) begin
      case (k)
        0: tk[i] = 65535;
        1: tk[i] = $urandom_range(1) ? 65535 : 0;
        2: tk[i] = $urandom_range(0, 40);
        default: tk[i] = $urandom_range(2, 30);
      endcase
    end
    apb_write(REG_LIMIT_VX, sp[0]);
    apb_write(REG_LIMIT_VY, sp[1]);
    apb_write(REG_LIMIT_VYAW, sp[2]);
    apb_write(REG_ODOM_LIM, tk[0]);
    apb_write(REG_TRAJ_BASE, tk[1]);
    apb_write(REG_BEAT_LIM, tk[2]);
    apb_write(REG_CMD_LIM, tk[3]);
  endtask

  initial begin
    gate_sb  = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_TICK;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: walk down the reason priority list, then corner commands
    send_event(make_event(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
    send_event(make_event(OP_ENABLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1));
    send_event(make_event(OP_ESTOP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_ESTOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_ODOM, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_BEAT, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_TRAJ, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'hFFFF, 1'b0));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_COMMAND, 16'h7FFF, 16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_COMMAND, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    // disabling drops the held command
    send_event(make_event(OP_ENABLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_ENABLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_TRAJ, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    send_event(make_event(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
    settle();

    // Random chunks, each under its own register setting; pairs of chunks share an idle pattern
    for (int k = 0; k < NUM_CHUNKS; k++) begin
      if (k < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 50;
      end else if (k < 4) begin
        send_idle_pct = 50;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(k);
      // bring every source up so the gate can open
      send_event(make_event(OP_ENABLE, rand_speed(), rand_speed(), rand_speed(), 1'b1,
                            16'h0000, 1'b1));
      send_event(make_event(OP_ESTOP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
      send_event(make_event(OP_ODOM, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
      send_event(make_event(OP_BEAT, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0));
      send_event(make_event(OP_TRAJ, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                            TICKS_W'($urandom_range(0, 40)), 1'b0));
      send_event(make_event(OP_COMMAND, rand_speed(), rand_speed(), rand_speed(), 1'b1,
                            16'h0000, 1'b0));
      for (int n = 0; n < CHUNK_ITEMS; n++) send_event(rand_event());
      settle();
    end

    if (gate_sb.errors == 0) begin
      $display("tb_velocity_command_safety_gate: clean");
    end else begin
      $display("tb_velocity_command_safety_gate: errors");
    end
    $finish;
  end

endmodule

@@ velocity_command_safety_gate.f @@
src/vcsg_pkg.sv
src/velocity_command_safety_gate.sv
tb/gate_check_pkg.sv
tb/tb_velocity_command_safety_gate.sv
